// ----- sv/quaternion_rotate_project_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef QUATERNION_ROTATE_PROJECT_ASSERT_SVH
`define QUATERNION_ROTATE_PROJECT_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define QR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define QR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/qrot_pkg.sv -----
package qrot_pkg;

    // Field widths.
    localparam int AW = 24;          // acceleration, 16 fraction bits
    localparam int QW = 16;          // quaternion component, Q2.14
    localparam int DW = 16;          // direction component, Q2.14
    localparam int OW = 32;          // result width

    // Internal widths of the datapath.
    localparam int PQW = QW + DW;    // q * d product, 28 fraction bits
    localparam int TW  = PQW + 2;    // sum of three products
    localparam int TQW = TW + QW;    // t * q product, 42 fraction bits
    localparam int RSH1 = 14;        // rounding to 28 fraction bits
    localparam int RW  = TQW - RSH1; // rotated component
    localparam int PAW = RW + AW;    // r * a product, 44 fraction bits
    localparam int SW  = PAW + 2;    // dot product sum
    localparam int RSH2 = 28;        // rounding to 16 fraction bits

    // Number of register stages in the pipeline.
    localparam int NSTAGE = 6;

    // Configuration register reset values.
    localparam logic [DW-1:0] DIR_X_RESET = 16'h4000;
    localparam logic [DW-1:0] DIR_Y_RESET = 16'h0000;
    localparam logic [DW-1:0] DIR_Z_RESET = 16'h0000;

    // APB address width and register indexes (word addressed).
    localparam int PAW_APB = 4;
    typedef enum logic [1:0] {
        REG_DIR_X = 2'd0,
        REG_DIR_Y = 2'd1,
        REG_DIR_Z = 2'd2
    } qrot_reg_t;

    // Per-stage load enables from the pipeline control to the datapath.
    typedef struct packed {
        logic [NSTAGE-1:0] load;
    } qrot_ctl_t;

endpackage

// ----- sv/qrot_datapath.sv -----
module qrot_datapath (
    input  logic                              aclk,
    input  qrot_pkg::qrot_ctl_t               ctl,
    input  logic signed [qrot_pkg::AW-1:0]    accel_x,
    input  logic signed [qrot_pkg::AW-1:0]    accel_y,
    input  logic signed [qrot_pkg::AW-1:0]    accel_z,
    input  logic signed [qrot_pkg::QW-1:0]    quat_w,
    input  logic signed [qrot_pkg::QW-1:0]    quat_i,
    input  logic signed [qrot_pkg::QW-1:0]    quat_j,
    input  logic signed [qrot_pkg::QW-1:0]    quat_k,
    input  logic signed [qrot_pkg::DW-1:0]    dir_x,
    input  logic signed [qrot_pkg::DW-1:0]    dir_y,
    input  logic signed [qrot_pkg::DW-1:0]    dir_z,
    output logic signed [qrot_pkg::OW-1:0]    component
);
    import qrot_pkg::*;

    logic signed [QW-1:0]  q_in   [4];
    logic signed [DW-1:0]  d_in   [3];
    logic signed [AW-1:0]  acc_in [3];

    logic signed [PQW-1:0] p1_next [12];
    logic signed [PQW-1:0] p1_reg  [12];
    logic signed [QW-1:0]  q1_reg  [4];
    logic signed [AW-1:0]  acc1_reg [3];

    logic signed [TW-1:0]  t_next  [4];
    logic signed [TW-1:0]  t_reg   [4];
    logic signed [QW-1:0]  q2_reg  [4];
    logic signed [AW-1:0]  acc2_reg [3];

    logic signed [TQW-1:0] m_next  [12];
    logic signed [TQW-1:0] m_reg   [12];
    logic signed [AW-1:0]  acc3_reg [3];

    logic signed [TQW-1:0] rsum    [3];
    logic signed [RW-1:0]  r_next  [3];
    logic signed [RW-1:0]  r_reg   [3];
    logic signed [AW-1:0]  acc4_reg [3];

    logic signed [PAW-1:0] pa_next [3];
    logic signed [PAW-1:0] pa_reg  [3];

    logic signed [SW-1:0]  dot_sum;
    logic signed [SW-1:0]  dot_rnd;
    logic signed [OW-1:0]  comp_next;
    logic signed [OW-1:0]  comp_reg;

    assign q_in[0]   = quat_w;
    assign q_in[1]   = quat_i;
    assign q_in[2]   = quat_j;
    assign q_in[3]   = quat_k;
    assign d_in[0]   = dir_x;
    assign d_in[1]   = dir_y;
    assign d_in[2]   = dir_z;
    assign acc_in[0] = accel_x;
    assign acc_in[1] = accel_y;
    assign acc_in[2] = accel_z;

    // Stage 1: the twelve products of conj(q) * d, grouped per output component.
    always_comb begin
        p1_next[0]  = PQW'(q_in[1]) * PQW'(d_in[0]);
        p1_next[1]  = PQW'(q_in[2]) * PQW'(d_in[1]);
        p1_next[2]  = PQW'(q_in[3]) * PQW'(d_in[2]);
        p1_next[3]  = PQW'(q_in[0]) * PQW'(d_in[0]);
        p1_next[4]  = PQW'(q_in[2]) * PQW'(d_in[2]);
        p1_next[5]  = PQW'(q_in[3]) * PQW'(d_in[1]);
        p1_next[6]  = PQW'(q_in[0]) * PQW'(d_in[1]);
        p1_next[7]  = PQW'(q_in[1]) * PQW'(d_in[2]);
        p1_next[8]  = PQW'(q_in[3]) * PQW'(d_in[0]);
        p1_next[9]  = PQW'(q_in[0]) * PQW'(d_in[2]);
        p1_next[10] = PQW'(q_in[1]) * PQW'(d_in[1]);
        p1_next[11] = PQW'(q_in[2]) * PQW'(d_in[0]);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            p1_reg   <= p1_next;
            q1_reg   <= q_in;
            acc1_reg <= acc_in;
        end
    end

    // Stage 2: sum the products into t = conj(q) * d, exact with 28 fraction bits.
    always_comb begin
        t_next[0] = TW'(p1_reg[0]) + TW'(p1_reg[1])  + TW'(p1_reg[2]);
        t_next[1] = TW'(p1_reg[3]) - TW'(p1_reg[4])  + TW'(p1_reg[5]);
        t_next[2] = TW'(p1_reg[6]) + TW'(p1_reg[7])  - TW'(p1_reg[8]);
        t_next[3] = TW'(p1_reg[9]) - TW'(p1_reg[10]) + TW'(p1_reg[11]);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            t_reg    <= t_next;
            q2_reg   <= q1_reg;
            acc2_reg <= acc1_reg;
        end
    end

    // Stage 3: the twelve products of t * q that feed the vector part.
    always_comb begin
        m_next[0]  = TQW'(t_reg[0]) * TQW'(q2_reg[1]);
        m_next[1]  = TQW'(t_reg[1]) * TQW'(q2_reg[0]);
        m_next[2]  = TQW'(t_reg[2]) * TQW'(q2_reg[3]);
        m_next[3]  = TQW'(t_reg[3]) * TQW'(q2_reg[2]);
        m_next[4]  = TQW'(t_reg[0]) * TQW'(q2_reg[2]);
        m_next[5]  = TQW'(t_reg[1]) * TQW'(q2_reg[3]);
        m_next[6]  = TQW'(t_reg[2]) * TQW'(q2_reg[0]);
        m_next[7]  = TQW'(t_reg[3]) * TQW'(q2_reg[1]);
        m_next[8]  = TQW'(t_reg[0]) * TQW'(q2_reg[3]);
        m_next[9]  = TQW'(t_reg[1]) * TQW'(q2_reg[2]);
        m_next[10] = TQW'(t_reg[2]) * TQW'(q2_reg[1]);
        m_next[11] = TQW'(t_reg[3]) * TQW'(q2_reg[0]);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            m_reg    <= m_next;
            acc3_reg <= acc2_reg;
        end
    end

    // Stage 4: vector part of t * q, rounded half up to 28 fraction bits.
    always_comb begin
        rsum[0] = m_reg[0] + m_reg[1] + m_reg[2]  - m_reg[3];
        rsum[1] = m_reg[4] - m_reg[5] + m_reg[6]  + m_reg[7];
        rsum[2] = m_reg[8] + m_reg[9] - m_reg[10] + m_reg[11];
        for (int k = 0; k < 3; k++) begin
            r_next[k] = RW'((rsum[k] + (TQW'(1) <<< (RSH1 - 1))) >>> RSH1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            r_reg    <= r_next;
            acc4_reg <= acc3_reg;
        end
    end

    // Stage 5: products of the rotated direction with the acceleration.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pa_next[k] = PAW'(r_reg[k]) * PAW'(acc4_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[4]) begin
            pa_reg <= pa_next;
        end
    end

    // Stage 6: dot product, round half up to 16 fraction bits, saturate to 32 bits.
    always_comb begin
        dot_sum = SW'(pa_reg[0]) + SW'(pa_reg[1]) + SW'(pa_reg[2]);
        dot_rnd = (dot_sum + (SW'(1) <<< (RSH2 - 1))) >>> RSH2;
        if ((&dot_rnd[SW-1:OW-1]) || !(|dot_rnd[SW-1:OW-1])) begin
            comp_next = dot_rnd[OW-1:0];
        end else if (dot_rnd[SW-1]) begin
            comp_next = {1'b1, {(OW-1){1'b0}}};
        end else begin
            comp_next = {1'b0, {(OW-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[5]) begin
            comp_reg <= comp_next;
        end
    end

    assign component = comp_reg;

endmodule

// ----- sv/quaternion_rotate_project.sv -----
// Channel  Direction  Handshake        Payload
// s_       in         s_valid/s_ready  accel_x/y/z (24b), quat_w/i/j/k (16b)
// m_       out        m_valid/m_ready  component (32b, saturated)
// apb      in         psel/penable     dir_x, dir_y, dir_z at 0x0, 0x4, 0x8
//
// One transaction is accepted per cycle unless a stalled output backs up the pipeline;
// each result passes through the six register stages of the multiply-add pipeline.
// Reset clears the stage valid bits and restores the direction registers.
// A stalled output holds; earlier stages keep filling bubbles, so nothing is
// lost or repeated.
module quaternion_rotate_project (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [qrot_pkg::AW-1:0]         s_accel_x,
    input  logic signed [qrot_pkg::AW-1:0]         s_accel_y,
    input  logic signed [qrot_pkg::AW-1:0]         s_accel_z,
    input  logic signed [qrot_pkg::QW-1:0]         s_quat_w,
    input  logic signed [qrot_pkg::QW-1:0]         s_quat_i,
    input  logic signed [qrot_pkg::QW-1:0]         s_quat_j,
    input  logic signed [qrot_pkg::QW-1:0]         s_quat_k,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [qrot_pkg::OW-1:0]         m_component,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [qrot_pkg::PAW_APB-1:0]           paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import qrot_pkg::*;

    logic [DW-1:0]     dir_x_reg, dir_y_reg, dir_z_reg;
    logic              cfg_write;
    logic [NSTAGE-1:0] valid_reg, valid_next;
    qrot_ctl_t         ctl;

    // Configuration registers, written in the APB access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_x_reg <= DIR_X_RESET;
            dir_y_reg <= DIR_Y_RESET;
            dir_z_reg <= DIR_Z_RESET;
        end else if (cfg_write) begin
            case (paddr[PAW_APB-1:2])
                REG_DIR_X: dir_x_reg <= pwdata[DW-1:0];
                REG_DIR_Y: dir_y_reg <= pwdata[DW-1:0];
                REG_DIR_Z: dir_z_reg <= pwdata[DW-1:0];
                default:   ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (paddr[PAW_APB-1:2])
            REG_DIR_X: prdata = {{(32-DW){1'b0}}, dir_x_reg};
            REG_DIR_Y: prdata = {{(32-DW){1'b0}}, dir_y_reg};
            REG_DIR_Z: prdata = {{(32-DW){1'b0}}, dir_z_reg};
            default:   prdata = 32'h0;
        endcase
    end

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        ctl.load[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            ctl.load[k] = !valid_reg[k] || ctl.load[k+1];
        end
    end

    // Valid bits follow the data through the stages.
    always_comb begin
        valid_next = valid_reg;
        if (ctl.load[0]) begin
            valid_next[0] = s_valid;
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (ctl.load[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = ctl.load[0];
    assign m_valid = valid_reg[NSTAGE-1];

    qrot_datapath u_datapath (
        .aclk      (aclk),
        .ctl       (ctl),
        .accel_x   (s_accel_x),
        .accel_y   (s_accel_y),
        .accel_z   (s_accel_z),
        .quat_w    (s_quat_w),
        .quat_i    (s_quat_i),
        .quat_j    (s_quat_j),
        .quat_k    (s_quat_k),
        .dir_x     (dir_x_reg),
        .dir_y     (dir_y_reg),
        .dir_z     (dir_z_reg),
        .component (m_component)
    );

endmodule

// ----- sv/qrot_checker.sv -----
`include "quaternion_rotate_project_assert.svh"

module qrot_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic signed [qrot_pkg::OW-1:0]  m_component,
    input logic                            pready
);

    // A result held back by the sink keeps its value.
    `QR_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_component), "result changed while stalled")

    // When the sink takes results, every stage can advance, so input is taken.
    `QR_ASSERT(a_no_bubble_stall, aclk, aresetn, m_ready |-> s_ready, "input stalled although output is free")

    // Reset empties the pipeline and leaves it ready.
    `QR_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid && s_ready, "pipeline not empty after reset")

    // The configuration port never inserts wait states.
    `QR_ASSERT_ALWAYS(a_pready_high, aclk, pready, "pready dropped")

endmodule

bind quaternion_rotate_project qrot_checker u_qrot_checker (.*);

// ----- tb/testbench.sv -----
module testbench;
    import qrot_pkg::*;

    // One input transaction, with an optional hand-computed result.
    typedef struct packed {
        logic signed [AW-1:0] ax;
        logic signed [AW-1:0] ay;
        logic signed [AW-1:0] az;
        logic signed [QW-1:0] qw;
        logic signed [QW-1:0] qi;
        logic signed [QW-1:0] qj;
        logic signed [QW-1:0] qk;
        logic                 known;
        logic signed [OW-1:0] comp;
    } sample_t;

    // Quaternion with wide integer components, order (w, x, y, z).
    typedef struct packed {
        longint w;
        longint x;
        longint y;
        longint z;
    } quat_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [AW-1:0] s_accel_x;
    logic signed [AW-1:0] s_accel_y;
    logic signed [AW-1:0] s_accel_z;
    logic signed [QW-1:0] s_quat_w;
    logic signed [QW-1:0] s_quat_i;
    logic signed [QW-1:0] s_quat_j;
    logic signed [QW-1:0] s_quat_k;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [OW-1:0] m_component;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PAW_APB-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // Direction held by the testbench, mirrored from every register write.
    logic signed [DW-1:0] dir_x;
    logic signed [DW-1:0] dir_y;
    logic signed [DW-1:0] dir_z;

    logic signed [OW-1:0] pending_components[$];
    sample_t              directed_rows[$];
    int                   n_errors;
    int                   n_sent;
    int                   n_checked;
    int                   n_reg_writes;
    bit                   idling_on;
    bit                   hold_request;

    quaternion_rotate_project uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_accel_x  (s_accel_x),
        .s_accel_y  (s_accel_y),
        .s_accel_z  (s_accel_z),
        .s_quat_w   (s_quat_w),
        .s_quat_i   (s_quat_i),
        .s_quat_j   (s_quat_j),
        .s_quat_k   (s_quat_k),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_component(m_component),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Clock with a period of two time units.
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hamilton product of two quaternions.
    function automatic quat_t ham_mul(input quat_t a, input quat_t b);
        quat_t o;
        o.w = a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z;
        o.x = a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y;
        o.y = a.w * b.y - a.x * b.z + a.y * b.w + a.z * b.x;
        o.z = a.w * b.z + a.x * b.y - a.y * b.x + a.z * b.w;
        return o;
    endfunction

    // Rotate the direction by conj(q) * d * q and project the acceleration onto it.
    function automatic logic signed [OW-1:0] project_component(input sample_t sm);
        quat_t  q;
        quat_t  qc;
        quat_t  d;
        quat_t  r;
        longint rx;
        longint ry;
        longint rz;
        longint a_x;
        longint a_y;
        longint a_z;
        longint sum;
        q.w  = $signed(sm.qw);
        q.x  = $signed(sm.qi);
        q.y  = $signed(sm.qj);
        q.z  = $signed(sm.qk);
        qc.w = q.w;
        qc.x = -q.x;
        qc.y = -q.y;
        qc.z = -q.z;
        d.w  = 0;
        d.x  = dir_x;
        d.y  = dir_y;
        d.z  = dir_z;
        r    = ham_mul(ham_mul(qc, d), q);
        // Round each rotated component from 42 to 28 fraction bits, half up.
        rx  = r.x;
        ry  = r.y;
        rz  = r.z;
        rx  = (rx + 64'sd8192) >>> 14;
        ry  = (ry + 64'sd8192) >>> 14;
        rz  = (rz + 64'sd8192) >>> 14;
        a_x = $signed(sm.ax);
        a_y = $signed(sm.ay);
        a_z = $signed(sm.az);
        // Dot product at 44 fraction bits, rounded to 16, then saturated.
        sum = rx * a_x + ry * a_y + rz * a_z;
        sum = (sum + 64'sd134217728) >>> 28;
        if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
        end
        if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
        end
        return sum[OW-1:0];
    endfunction

    task automatic add_row(input int ax, input int ay, input int az, input int qw,
                           input int qi, input int qj, input int qk,
                           input bit known, input int comp);
        sample_t sm;
        sm.ax    = ax[AW-1:0];
        sm.ay    = ay[AW-1:0];
        sm.az    = az[AW-1:0];
        sm.qw    = qw[QW-1:0];
        sm.qi    = qi[QW-1:0];
        sm.qj    = qj[QW-1:0];
        sm.qk    = qk[QW-1:0];
        sm.known = known;
        sm.comp  = comp;
        directed_rows.push_back(sm);
    endtask

    function automatic logic signed [AW-1:0] rand_accel();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h0080_0000;
                    1: v = 32'h007F_FFFF;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            1: v = {{14{v[17]}}, v[17:0]};
            default: ;
        endcase
        return v[AW-1:0];
    endfunction

    function automatic logic signed [QW-1:0] rand_quat();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 5))
                0: v = 32'h8000;
                1: v = 32'h7FFF;
                2: v = 32'h0000;
                3: v = 32'h4000;
                4: v = 32'hC000;
                default: v = 32'hFFFF;
            endcase
        end
        return v[QW-1:0];
    endfunction

    function automatic sample_t rand_sample();
        sample_t sm;
        sm.ax    = rand_accel();
        sm.ay    = rand_accel();
        sm.az    = rand_accel();
        sm.qw    = rand_quat();
        sm.qi    = rand_quat();
        sm.qj    = rand_quat();
        sm.qk    = rand_quat();
        sm.known = 1'b0;
        sm.comp  = '0;
        return sm;
    endfunction

    // Offer one transaction, with an optional gap before it, and record its result.
    task automatic offer(input sample_t sm);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_accel_x <= sm.ax;
        s_accel_y <= sm.ay;
        s_accel_z <= sm.az;
        s_quat_w  <= sm.qw;
        s_quat_i  <= sm.qi;
        s_quat_j  <= sm.qj;
        s_quat_k  <= sm.qk;
        do @(posedge aclk); while (!s_ready);
        if (sm.known) begin
            pending_components.push_back(sm.comp);
        end else begin
            pending_components.push_back(project_component(sm));
        end
        n_sent++;
    endtask

    // Register write: setup cycle, access cycle, then the bus returns to idle.
    task automatic reg_write(input qrot_reg_t idx, input logic signed [DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(32-DW){value[DW-1]}}, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DIR_X: dir_x = value;
            REG_DIR_Y: dir_y = value;
            REG_DIR_Z: dir_z = value;
            default: ;
        endcase
        n_reg_writes++;
        @(posedge aclk);
    endtask

    // Register read, compared with the value the testbench expects.
    task automatic reg_check(input qrot_reg_t idx, input logic [DW-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[DW-1:0] !== want) begin
            $display("%0t: register %s read mismatch: expected %h, actual %h",
                     $time, idx.name(), want, prdata[DW-1:0]);
            n_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop offering and wait until every recorded result has come out.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_components.size() != 0);
    endtask

    // Compare every result transaction with the oldest pending expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_components.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %0d",
                         $time, m_component);
                n_errors++;
            end else begin
                if (m_component !== pending_components[0]) begin
                    $display("%0t: component mismatch: expected %0d, actual %0d",
                             $time, pending_components[0], m_component);
                    n_errors++;
                end
                void'(pending_components.pop_front());
                n_checked++;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        m_ready    = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 299;
                m_ready     <= 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    // Stimulus: reset, directed table, then random phases under several directions.
    initial begin
        sample_t              sm;
        int                   ph;
        int                   k;
        logic signed [DW-1:0] px;
        logic signed [DW-1:0] py;
        logic signed [DW-1:0] pz;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_accel_x    = '0;
        s_accel_y    = '0;
        s_accel_z    = '0;
        s_quat_w     = '0;
        s_quat_i     = '0;
        s_quat_j     = '0;
        s_quat_k     = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        n_errors     = 0;
        n_sent       = 0;
        n_checked    = 0;
        n_reg_writes = 0;
        idling_on    = 1'b1;
        hold_request = 1'b0;
        dir_x        = DIR_X_RESET;
        dir_y        = DIR_Y_RESET;
        dir_z        = DIR_Z_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers come out of reset with the unit x direction.
        reg_check(REG_DIR_X, DIR_X_RESET);
        reg_check(REG_DIR_Y, DIR_Y_RESET);
        reg_check(REG_DIR_Z, DIR_Z_RESET);

        // Identity rotation passes accel x straight through.
        add_row(65536, 0, 0, 16384, 0, 0, 0, 1, 65536);
        add_row(8388607, 8388607, 8388607, 16384, 0, 0, 0, 1, 8388607);
        add_row(-8388608, -8388608, -8388608, 16384, 0, 0, 0, 1, -8388608);
        add_row(0, 8388607, -8388608, 16384, 0, 0, 0, 1, 0);
        // A zero quaternion collapses the direction.
        add_row(8388607, 8388607, 8388607, 0, 0, 0, 0, 1, 0);
        // The negated identity gives the same rotation.
        add_row(65536, 123, -77, -16384, 0, 0, 0, 1, 65536);
        // Half turn about z flips the x direction.
        add_row(65536, 0, 0, 0, 0, 0, 16384, 1, -65536);
        // Non-unit quaternions, extremes and rounding near zero.
        add_row(65536, 0, 0, 11585, 0, 0, 11585, 0, 0);
        add_row(8388607, 8388607, 8388607, 32767, 32767, 32767, 32767, 0, 0);
        add_row(-8388608, -8388608, -8388608, -32768, -32768, -32768, -32768, 0, 0);
        add_row(8388607, -8388608, 8388607, -32768, 32767, -32768, 32767, 0, 0);
        add_row(1, -1, 1, 32767, 0, 0, 0, 0, 0);
        add_row(-1, -1, -1, -1, -1, -1, -1, 0, 0);
        add_row(12345, -54321, 99999, 8192, -8192, 8192, -8192, 0, 0);
        add_row(-8388608, 8388607, 0, 0, 32767, 0, 0, 0, 0);
        add_row(0, 0, 8388607, 0, 0, 32767, -32768, 0, 0);
        add_row(3, 5, 7, 1, 2, 3, 4, 0, 0);
        foreach (directed_rows[i]) begin
            offer(directed_rows[i]);
        end

        // Random phases, each with its own direction.
        for (ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: begin px = -16'sd32768; py = -16'sd32768; pz = -16'sd32768; end
                1: begin px = 16'sd32767;  py = 16'sd32767;  pz = 16'sd32767;  end
                2: begin px = 16'sd0;      py = 16'sd16384;  pz = 16'sd0;      end
                3: begin px = 16'sd0;      py = 16'sd0;      pz = -16'sd16384; end
                5: begin px = 16'sd32767;  py = -16'sd32768; pz = 16'sd1;      end
                default: begin
                    px = DW'($urandom);
                    py = DW'($urandom);
                    pz = DW'($urandom);
                end
            endcase
            reg_write(REG_DIR_X, px);
            reg_write(REG_DIR_Y, py);
            reg_write(REG_DIR_Z, pz);
            reg_check(REG_DIR_X, px);
            reg_check(REG_DIR_Y, py);
            reg_check(REG_DIR_Z, pz);
            // Long receiver hold-off so the pipeline fills and backs up.
            if (ph == 6) begin
                hold_request = 1'b1;
            end
            // The closing phase runs at full rate on both sides.
            if (ph == 7) begin
                idling_on = 1'b0;
            end
            for (k = 0; k < 80; k++) begin
                sm = rand_sample();
                offer(sm);
            end
        end

        drain();
        repeat (NSTAGE * 2) @(posedge aclk);
        $display("Checked %0d results from %0d transactions under %0d register writes,",
                 n_checked, n_sent, n_reg_writes);
        $display("covering field extremes, non-unit rotations and a long output stall.");
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #400000;
        $display("Timeout with %0d results still pending.", pending_components.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
